[rtl/core/fkct_pkg.sv]
// ----------------------------------------------------------------------------
// FM key code transposer package
// Shared types, register indexes, address constants and note tables.
// ----------------------------------------------------------------------------
package fkct_pkg;

   localparam int DefaultChannels = 8;
   localparam int MaxChannels     = 8;

   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 8;

   typedef enum logic [CsrIndexW-1:0] {
      CsrShiftOctaves       = 2'd0,
      CsrShiftSemitones     = 2'd1,
      CsrShiftFractionSteps = 2'd2
   } csr_index_type;

   localparam logic [7:0] KeyCodeFirst = 8'h28;
   localparam logic [7:0] KeyCodeLast  = 8'h2F;
   localparam logic [7:0] KeyFracFirst = 8'h30;
   localparam logic [7:0] KeyFracLast  = 8'h37;

   localparam logic [7:0] FracTop   = 8'hFC;
   localparam logic [3:0] NoteTop   = 4'hF;
   localparam logic [2:0] OctaveTop = 3'd7;
   // Highest linear semitone position: octave 7, note E.
   localparam logic [7:0] PosTop    = 8'd95;

   typedef struct packed {
      logic signed [4:0] octaves;
      logic signed [4:0] semitones;
      logic signed [7:0] fraction_steps;
   } shift_type;

   typedef struct packed {
      logic [7:0] code;
      logic [7:0] fraction;
   } key_type;

   typedef struct packed {
      logic hit;
      logic is_code;
   } access_type;

   // Semitone index of a note when it steps up; an unused code acts as the note below it.
   function automatic logic [3:0] index_up(input logic [3:0] note);
      logic [3:0] triple;
      triple = {1'b0, note[3:2], 1'b0} + {2'b00, note[3:2]};
      if (note[1:0] == 2'd3) begin
         return triple + 4'd2;
      end else begin
         return triple + {2'b00, note[1:0]};
      end
   endfunction

   // Semitone index of a note when it steps down; an unused code acts as the note above it.
   function automatic logic [3:0] index_down(input logic [3:0] note);
      logic [3:0] triple;
      triple = {1'b0, note[3:2], 1'b0} + {2'b00, note[3:2]};
      if (note[1:0] == 2'd3) begin
         return triple + 4'd3;
      end else begin
         return triple + {2'b00, note[1:0]};
      end
   endfunction

   function automatic logic [3:0] note_of_index(input logic [3:0] index);
      logic [3:0] note;
      case (index)
         4'd0:    note = 4'h0;
         4'd1:    note = 4'h1;
         4'd2:    note = 4'h2;
         4'd3:    note = 4'h4;
         4'd4:    note = 4'h5;
         4'd5:    note = 4'h6;
         4'd6:    note = 4'h8;
         4'd7:    note = 4'h9;
         4'd8:    note = 4'hA;
         4'd9:    note = 4'hC;
         4'd10:   note = 4'hD;
         4'd11:   note = 4'hE;
         default: note = 4'h0;
      endcase
      return note;
   endfunction

endpackage

[rtl/core/fm_key_code_transposer_unit.sv]
// ----------------------------------------------------------------------------
// FM key code transposer unit
// Transposes key code and key fraction writes of an FM register stream.
// ----------------------------------------------------------------------------
// Each transaction is one chip register write. Writes to the key code
// registers 0x28-0x2F and key fraction registers 0x30-0x37 update the
// channel's stored pair, and the unit returns the stored pitch lowered by the
// programmed octave, semitone and 1/64 semitone shift, clipped at both ends.
// All other writes pass through unchanged. The unit takes one transaction per
// cycle unless the result register is stalled; one pass of transposition
// logic sits between the input register and the result register, and the
// store is written as the result register loads, so back-to-back writes to
// one channel see each other. The user must write the shift registers only
// while no transaction is in flight; the unit does not enforce this.
module fm_key_code_transposer_unit #(
   parameter int CHANNELS = fkct_pkg::DefaultChannels
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_reg_address,
   input  logic [7:0]                     req_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_address,
   output logic [7:0]                     rsp_out_data,
   output logic                           rsp_was_rewritten,
   input  logic                           csr_write_enable,
   input  logic [fkct_pkg::CsrIndexW-1:0] csr_index,
   input  logic [fkct_pkg::CsrDataW-1:0]  csr_write_data
);

   fkct_pkg::shift_type  shift_ff;
   fkct_pkg::shift_type  shift_in;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [7:0]           s1_addr_ff;
   logic [7:0]           s1_addr_in;
   logic [7:0]           s1_data_ff;
   logic [7:0]           s1_data_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [7:0]           rsp_addr_ff;
   logic [7:0]           rsp_addr_in;
   logic [7:0]           rsp_data_ff;
   logic [7:0]           rsp_data_in;
   logic                 rsp_rew_ff;
   logic                 rsp_rew_in;
   logic                 s1_move;
   logic                 req_fire;
   fkct_pkg::access_type access;
   fkct_pkg::key_type    key;
   fkct_pkg::key_type    result;

   always_comb begin
      shift_in = shift_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            fkct_pkg::CsrShiftOctaves:       shift_in.octaves        = csr_write_data[4:0];
            fkct_pkg::CsrShiftSemitones:     shift_in.semitones      = csr_write_data[4:0];
            fkct_pkg::CsrShiftFractionSteps: shift_in.fraction_steps = csr_write_data;
            default: ;
         endcase
      end
   end

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_fire  = req_valid && req_ready;

   fkct_channel_store #(
      .CHANNELS (CHANNELS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .reg_address (s1_addr_ff),
      .write_data  (s1_data_ff),
      .commit      (s1_move),
      .access      (access),
      .key         (key)
   );

   fkct_transpose u_transpose (
      .key    (key),
      .shift  (shift_ff),
      .result (result)
   );

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_addr_in   = req_fire ? req_reg_address : s1_addr_ff;
      s1_data_in   = req_fire ? req_write_data : s1_data_ff;
      rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_rew_in   = rsp_rew_ff;
      if (s1_move) begin
         rsp_addr_in = s1_addr_ff;
         rsp_rew_in  = access.hit;
         if (!access.hit) begin
            rsp_data_in = s1_data_ff;
         end else if (access.is_code) begin
            rsp_data_in = result.code;
         end else begin
            rsp_data_in = result.fraction;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      s1_data_ff  <= s1_data_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_rew_ff  <= rsp_rew_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_address   = rsp_addr_ff;
   assign rsp_out_data      = rsp_data_ff;
   assign rsp_was_rewritten = rsp_rew_ff;

endmodule

[rtl/core/fkct_channel_store.sv]
// ----------------------------------------------------------------------------
// FM key code transposer channel store
// Decodes key register writes and keeps the per-channel key code and fraction.
// ----------------------------------------------------------------------------
module fkct_channel_store #(
   parameter int CHANNELS = fkct_pkg::DefaultChannels
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             reg_address,
   input  logic [7:0]             write_data,
   input  logic                   commit,
   output fkct_pkg::access_type   access,
   output fkct_pkg::key_type      key
);

   localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [7:0]        code_ff [CHANNELS];
   logic [7:0]        code_in [CHANNELS];
   logic [7:0]        frac_ff [CHANNELS];
   logic [7:0]        frac_in [CHANNELS];
   logic [2:0]        channel;
   logic [ChIdxW-1:0] ch_idx;
   logic              in_range;

   assign channel  = reg_address[2:0];
   assign ch_idx   = channel[ChIdxW-1:0];
   assign in_range = (reg_address >= fkct_pkg::KeyCodeFirst) &&
                     (reg_address <= fkct_pkg::KeyFracLast);

   assign access.is_code = reg_address <= fkct_pkg::KeyCodeLast;
   assign access.hit     = in_range && ({1'b0, channel} < 4'(CHANNELS));

   assign key.code     = access.is_code ? write_data : code_ff[ch_idx];
   assign key.fraction = access.is_code ? frac_ff[ch_idx] : write_data;

   always_comb begin
      code_in = code_ff;
      frac_in = frac_ff;
      if (commit && access.hit) begin
         if (access.is_code) begin
            code_in[ch_idx] = write_data;
         end else begin
            frac_in[ch_idx] = write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            code_ff[i] <= '0;
            frac_ff[i] <= '0;
         end
      end else begin
         code_ff <= code_in;
         frac_ff <= frac_in;
      end
   end

endmodule

[rtl/core/fkct_transpose.sv]
// ----------------------------------------------------------------------------
// FM key code transposer pitch shift
// Shifts a key code and fraction by octaves, semitones and fraction steps.
// ----------------------------------------------------------------------------
module fkct_transpose (
   input  fkct_pkg::key_type   key,
   input  fkct_pkg::shift_type shift,
   output fkct_pkg::key_type   result
);

   logic [6:0]  oct_raw;
   logic        oct_top;
   logic        oct_bottom;
   logic        oct_ok;
   logic [2:0]  oct;
   logic [3:0]  note;
   logic [6:0]  base;
   logic [6:0]  p_up0;
   logic [6:0]  p_dn0;

   logic        semi_up;
   logic        semi_dn;
   logic [4:0]  semi_n;
   logic        semi_moved;
   logic [7:0]  p_s_up;
   logic [7:0]  p_s_dn;
   logic        clip_top_s;
   logic        clip_bot_s;
   logic        clip_s;
   logic [6:0]  semi_pos;
   logic [6:0]  cur_up;
   logic [6:0]  cur_dn;

   logic        frac_up_dir;
   logic        frac_dn_dir;
   logic [7:0]  frac_m;
   logic [5:0]  q0;
   logic [7:0]  gap;
   logic [5:0]  k0;
   logic        wrap_dn;
   logic        wrap_up;
   logic [7:0]  rem_dn;
   logic [7:0]  rem_up;
   logic [1:0]  fsteps;
   logic [7:0]  frac_new;
   logic [7:0]  p_f;
   logic        clip_top_f;
   logic        clip_bot_f;

   logic [13:0] prod;
   logic [2:0]  oct_e;
   logic [6:0]  idx_wide;
   logic [3:0]  note_e;
   logic        clip_top;
   logic        clip_bottom;

   assign oct_raw    = {3'b000, key.code[7:4]} - {{2{shift.octaves[4]}}, shift.octaves};
   assign oct_bottom = oct_raw[6];
   assign oct_top    = !oct_raw[6] && (oct_raw[5:3] != 3'b000);
   assign oct_ok     = !oct_top && !oct_bottom;
   assign oct        = oct_raw[2:0];
   assign note       = key.code[3:0];
   assign base       = {1'b0, oct, 3'b000} + {2'b00, oct, 2'b00};
   assign p_up0      = base + {3'b000, fkct_pkg::index_up(note)};
   assign p_dn0      = base + {3'b000, fkct_pkg::index_down(note)};

   assign semi_up    = shift.semitones[4];
   assign semi_dn    = !shift.semitones[4] && (shift.semitones != 5'sd0);
   assign semi_n     = semi_up ? (5'd0 - shift.semitones) : shift.semitones;
   assign semi_moved = semi_n != 5'd0;
   assign p_s_up     = {1'b0, p_up0} + {3'b000, semi_n};
   assign p_s_dn     = {1'b0, p_dn0} - {3'b000, semi_n};
   assign clip_top_s = semi_up && (p_s_up > fkct_pkg::PosTop);
   assign clip_bot_s = semi_dn && p_s_dn[7];
   assign clip_s     = clip_top_s || clip_bot_s;
   assign semi_pos   = semi_up ? p_s_up[6:0] : p_s_dn[6:0];
   assign cur_up     = semi_moved ? semi_pos : p_up0;
   assign cur_dn     = semi_moved ? semi_pos : p_dn0;

   assign frac_up_dir = shift.fraction_steps[7];
   assign frac_dn_dir = !shift.fraction_steps[7] && (shift.fraction_steps != 8'sd0);
   assign frac_m      = frac_up_dir ? (8'd0 - shift.fraction_steps) : shift.fraction_steps;
   assign q0          = key.fraction[7:2];
   assign gap         = fkct_pkg::FracTop - key.fraction;
   assign k0          = (key.fraction > fkct_pkg::FracTop) ? 6'd0 : gap[7:2];
   assign wrap_dn     = frac_m > {2'b00, q0};
   assign wrap_up     = frac_m > {2'b00, k0};
   assign rem_dn      = frac_m - {2'b00, q0} - 8'd1;
   assign rem_up      = frac_m - {2'b00, k0} - 8'd1;

   always_comb begin
      fsteps     = 2'd0;
      frac_new   = key.fraction;
      p_f        = {1'b0, cur_up};
      clip_top_f = 1'b0;
      clip_bot_f = 1'b0;
      if (frac_dn_dir) begin
         if (wrap_dn) begin
            fsteps   = 2'd1 + {1'b0, rem_dn[6]};
            frac_new = fkct_pkg::FracTop - {rem_dn[5:0], 2'b00};
         end else begin
            frac_new = key.fraction - {frac_m[5:0], 2'b00};
         end
         p_f        = {1'b0, cur_dn} - {6'd0, fsteps};
         clip_bot_f = p_f[7];
      end else if (frac_up_dir) begin
         if (wrap_up) begin
            fsteps   = 2'd1 + {1'b0, rem_up[6]};
            frac_new = {rem_up[5:0], 2'b00};
         end else begin
            frac_new = key.fraction + {frac_m[5:0], 2'b00};
         end
         p_f        = {1'b0, cur_up} + {6'd0, fsteps};
         clip_top_f = p_f > fkct_pkg::PosTop;
      end
   end

   // Position to octave by a reciprocal multiply, exact over the valid positions.
   assign prod     = {7'd0, p_f[6:0]} * 14'd43;
   assign oct_e    = prod[11:9];
   assign idx_wide = p_f[6:0] - ({1'b0, oct_e, 3'b000} + {2'b00, oct_e, 2'b00});
   assign note_e   = fkct_pkg::note_of_index(idx_wide[3:0]);

   assign clip_top    = oct_top || (oct_ok && (clip_top_s || (!clip_s && clip_top_f)));
   assign clip_bottom = oct_bottom || (oct_ok && (clip_bot_s || (!clip_s && clip_bot_f)));

   always_comb begin
      if (clip_top) begin
         result.code     = {1'b0, fkct_pkg::OctaveTop, fkct_pkg::NoteTop};
         result.fraction = fkct_pkg::FracTop;
      end else if (clip_bottom) begin
         result.code     = 8'h00;
         result.fraction = 8'h00;
      end else if (semi_moved || (fsteps != 2'd0)) begin
         result.code     = {1'b0, oct_e, note_e};
         result.fraction = frac_new;
      end else begin
         result.code     = {1'b0, oct, note};
         result.fraction = frac_new;
      end
   end

endmodule

[rtl/core/fkct_checker.sv]
// ----------------------------------------------------------------------------
// FM key code transposer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fkct_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_address,
   input logic [7:0] rsp_out_data,
   input logic       rsp_was_rewritten
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_address) &&
      $stable(rsp_out_data) && $stable(rsp_was_rewritten))
      else $error("result transaction changed while stalled");

   // Writes outside the key registers are never rewritten.
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_out_address < fkct_pkg::KeyCodeFirst) ||
      (rsp_out_address > fkct_pkg::KeyFracLast)) |-> !rsp_was_rewritten)
      else $error("non-key write marked as rewritten");

   // A rewritten key code never carries an octave above seven.
   a_code_octave: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_rewritten && (rsp_out_address <= fkct_pkg::KeyCodeLast)
      |-> !rsp_out_data[7])
      else $error("rewritten key code has octave above seven");

   // No result transaction is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind fm_key_code_transposer_unit fkct_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_address   (rsp_out_address),
   .rsp_out_data      (rsp_out_data),
   .rsp_was_rewritten (rsp_was_rewritten)
);

[test/fkct_transpose_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FM key code transposer checker
// Watches the request, response and shift register ports of the transposer.
// It keeps its own copy of the shifts and the per-channel key stores. For
// every accepted request it computes the rewritten register write. Each
// accepted response is compared field by field against the oldest expected
// write, and every mismatch is counted.
// ----------------------------------------------------------------------------
module fkct_transpose_checker #(
   parameter int CHANNELS = fkct_pkg::DefaultChannels
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [7:0]                     req_reg_address,
   input  logic [7:0]                     req_write_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [7:0]                     rsp_out_address,
   input  logic [7:0]                     rsp_out_data,
   input  logic                           rsp_was_rewritten,
   input  logic                           csr_write_enable,
   input  logic [fkct_pkg::CsrIndexW-1:0] csr_index,
   input  logic [fkct_pkg::CsrDataW-1:0]  csr_write_data,
   output int                             fail_count,
   output int                             pending_results
);

   localparam int NoteLast = 4'hE;

   typedef struct packed {
      logic [7:0] address;
      logic [7:0] data;
      logic       rewritten;
   } chip_write_type;

   logic signed [4:0] octave_shift;
   logic signed [4:0] semitone_shift;
   logic signed [7:0] fraction_shift;
   logic [7:0]        code_store [fkct_pkg::MaxChannels];
   logic [7:0]        fraction_store [fkct_pkg::MaxChannels];
   chip_write_type    expected_writes [$];
   chip_write_type    predicted;
   chip_write_type    oldest;
   fkct_pkg::key_type pitch;
   logic              is_code;
   logic              is_fraction;
   int                channel;

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   function automatic void clip_to_top(inout int oct, inout int note, inout int frac,
                                       inout bit clipped);
      oct     = fkct_pkg::OctaveTop;
      note    = fkct_pkg::NoteTop;
      frac    = fkct_pkg::FracTop;
      clipped = 1'b1;
   endfunction

   function automatic void clip_to_bottom(inout int oct, inout int note, inout int frac,
                                          inout bit clipped);
      oct     = 0;
      note    = 0;
      frac    = 0;
      clipped = 1'b1;
   endfunction

   // The unused note codes 3, 7, 11 and 15 are stepped over in both directions.
   function automatic void note_raise(inout int oct, inout int note, inout int frac,
                                      inout bit clipped);
      note += (((note + 1) & 3) == 3) ? 2 : 1;
      if (note > NoteLast) begin
         oct++;
         note = 0;
         if (oct > int'(fkct_pkg::OctaveTop)) begin
            clip_to_top(oct, note, frac, clipped);
         end
      end
   endfunction

   function automatic void note_lower(inout int oct, inout int note, inout int frac,
                                      inout bit clipped);
      note -= (((note + 3) & 3) == 3) ? 2 : 1;
      if (note < 0) begin
         oct--;
         note = NoteLast;
         if (oct < 0) begin
            clip_to_bottom(oct, note, frac, clipped);
         end
      end
   endfunction

   function automatic fkct_pkg::key_type pitch_lowered(input logic [7:0] code,
                                                       input logic [7:0] fraction);
      int                oct;
      int                note;
      int                frac;
      int                semis;
      int                fsteps;
      int                steps;
      bit                clipped;
      fkct_pkg::key_type result;
      semis   = int'(semitone_shift);
      fsteps  = int'(fraction_shift);
      oct     = int'(code[7:4]) - int'(octave_shift);
      note    = int'(code[3:0]);
      frac    = int'(fraction);
      clipped = 1'b0;
      if (oct > int'(fkct_pkg::OctaveTop)) begin
         clip_to_top(oct, note, frac, clipped);
      end else if (oct < 0) begin
         clip_to_bottom(oct, note, frac, clipped);
      end else begin
         steps = (semis < 0) ? -semis : semis;
         for (int i = 0; i < steps && !clipped; i++) begin
            if (semis > 0) begin
               note_lower(oct, note, frac, clipped);
            end else begin
               note_raise(oct, note, frac, clipped);
            end
         end
         steps = (fsteps < 0) ? -fsteps : fsteps;
         for (int i = 0; i < steps && !clipped; i++) begin
            if (fsteps > 0) begin
               frac -= 4;
               if (frac < 0) begin
                  frac = fkct_pkg::FracTop;
                  note_lower(oct, note, frac, clipped);
               end
            end else begin
               frac += 4;
               if (frac > int'(fkct_pkg::FracTop)) begin
                  frac = 0;
                  note_raise(oct, note, frac, clipped);
               end
            end
         end
      end
      result.code     = 8'((oct << 4) | note);
      result.fraction = 8'(frac);
      return result;
   endfunction

   task automatic check_field(input string name, input logic [7:0] expected,
                              input logic [7:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         octave_shift   = '0;
         semitone_shift = '0;
         fraction_shift = '0;
         for (int i = 0; i < fkct_pkg::MaxChannels; i++) begin
            code_store[i]     = '0;
            fraction_store[i] = '0;
         end
         expected_writes.delete();
         pending_results <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               fkct_pkg::CsrShiftOctaves:       octave_shift   = csr_write_data[4:0];
               fkct_pkg::CsrShiftSemitones:     semitone_shift = csr_write_data[4:0];
               fkct_pkg::CsrShiftFractionSteps: fraction_shift = csr_write_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h %h %b", $time,
                        rsp_out_address, rsp_out_data, rsp_was_rewritten);
               fail_count++;
            end else begin
               oldest = expected_writes.pop_front();
               check_field("out_address", oldest.address, rsp_out_address);
               check_field("out_data", oldest.data, rsp_out_data);
               check_field("was_rewritten", 8'(oldest.rewritten), 8'(rsp_was_rewritten));
            end
         end
         if (req_valid && req_ready) begin
            predicted.address   = req_reg_address;
            predicted.data      = req_write_data;
            predicted.rewritten = 1'b0;
            is_code     = (req_reg_address >= fkct_pkg::KeyCodeFirst) &&
                          (req_reg_address <= fkct_pkg::KeyCodeLast);
            is_fraction = (req_reg_address >= fkct_pkg::KeyFracFirst) &&
                          (req_reg_address <= fkct_pkg::KeyFracLast);
            if (is_code || is_fraction) begin
               channel = int'(req_reg_address -
                              (is_code ? fkct_pkg::KeyCodeFirst : fkct_pkg::KeyFracFirst));
               if (channel < CHANNELS) begin
                  if (is_code) begin
                     code_store[channel] = req_write_data;
                  end else begin
                     fraction_store[channel] = req_write_data;
                  end
                  pitch = pitch_lowered(code_store[channel], fraction_store[channel]);
                  predicted.data      = is_code ? pitch.code : pitch.fraction;
                  predicted.rewritten = 1'b1;
               end
            end
            expected_writes.push_back(predicted);
         end
         pending_results <= expected_writes.size();
      end
   end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FM key code transposer testbench
// Drives register write transactions into the transposer under a series of
// octave, semitone and fraction shifts, from directed corner cases to long
// random runs with random gaps, receiver stalls and long back-pressure holds.
// A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;

   localparam int ResetCycles   = 8;
   localparam int SettleCycles  = 8;
   localparam int RandomPhases  = 10;
   localparam int PhaseWrites   = 125;
   localparam int HoldCycles    = 300;
   localparam int CycleLimit    = 400000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_reg_address = '0;
   logic [7:0]                     req_write_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [7:0]                     rsp_out_address;
   logic [7:0]                     rsp_out_data;
   logic                           rsp_was_rewritten;
   logic                           csr_write_enable = 1'b0;
   logic [fkct_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [fkct_pkg::CsrDataW-1:0]  csr_write_data = '0;

   int fail_count;
   int pending_results;
   int req_gap_max = 12;
   int rsp_stall_max = 12;
   int rsp_hold_cycles = 0;
   int cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   fm_key_code_transposer_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_reg_address   (req_reg_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_address   (rsp_out_address),
      .rsp_out_data      (rsp_out_data),
      .rsp_was_rewritten (rsp_was_rewritten),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   fkct_transpose_checker #(
      .CHANNELS (fkct_pkg::DefaultChannels)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_reg_address   (req_reg_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_address   (rsp_out_address),
      .rsp_out_data      (rsp_out_data),
      .rsp_was_rewritten (rsp_was_rewritten),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_shift(input int octaves, input int semitones, input int fraction_steps);
      wait_until_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= fkct_pkg::CsrShiftOctaves;
      csr_write_data   <= fkct_pkg::CsrDataW'(octaves);
      @(posedge clock);
      csr_index        <= fkct_pkg::CsrShiftSemitones;
      csr_write_data   <= fkct_pkg::CsrDataW'(semitones);
      @(posedge clock);
      csr_index        <= fkct_pkg::CsrShiftFractionSteps;
      csr_write_data   <= fkct_pkg::CsrDataW'(fraction_steps);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_write(input logic [7:0] address, input logic [7:0] data);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_reg_address <= address;
      req_write_data  <= data;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_write();
      int         kind;
      logic [2:0] channel;
      logic [7:0] address;
      logic [7:0] data;
      kind    = $urandom_range(0, 9);
      channel = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 1)) : 3'($urandom);
      if (kind < 4) begin
         address = fkct_pkg::KeyCodeFirst + channel;
         data    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)};
      end else if (kind < 8) begin
         address = fkct_pkg::KeyFracFirst + channel;
         data    = 8'($urandom);
      end else begin
         address = 8'($urandom);
         data    = 8'($urandom);
      end
      send_write(address, data);
   endtask

   initial begin
      int stall;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, rsp_stall_max);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) begin
            @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      int sign;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      set_shift(1, 3, 10);
      send_write(8'h00, 8'h00);
      send_write(8'hFF, 8'hFF);
      send_write(8'h27, 8'h5A);
      send_write(8'h38, 8'hA5);
      send_write(8'h28, 8'h00);
      send_write(8'h2F, 8'hFF);
      send_write(8'h30, 8'h03);
      send_write(8'h37, 8'hFC);
      send_write(8'h29, 8'h53);
      send_write(8'h2A, 8'h47);
      send_write(8'h2C, 8'h8F);

      // An octave field above 7 overflows with no shift at all.
      set_shift(0, 0, 0);
      send_write(8'h2D, 8'h8E);
      send_write(8'h35, 8'h01);
      send_write(8'h2D, 8'h7E);

      // Mixed signs move semitones and fraction steps in opposite directions.
      set_shift(2, -5, 7);
      send_write(8'h28, 8'h40);
      send_write(8'h30, 8'h02);

      set_shift(8, 11, 64);
      send_write(8'h29, 8'h7E);
      send_write(8'h31, 8'hFF);

      set_shift(-8, -11, -64);
      send_write(8'h2A, 8'h00);
      send_write(8'h32, 8'h00);

      set_shift(0, 15, 127);
      send_write(8'h2B, 8'h7E);

      set_shift(0, -16, -128);
      send_write(8'h33, 8'h81);

      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: set_shift(0, 0, 0);
            1: set_shift(8, 11, 64);
            2: set_shift(-8, -11, -64);
            default: begin
               if ($urandom_range(0, 3) != 0) begin
                  sign = ($urandom_range(0, 1) == 0) ? 1 : -1;
                  set_shift(sign * $urandom_range(0, 8), sign * $urandom_range(0, 11),
                            sign * $urandom_range(0, 64));
               end else begin
                  set_shift($urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom_range(0, 255));
               end
            end
         endcase
         req_gap_max   = (phase % 3 == 1) ? 0 : 12;
         rsp_stall_max = (phase % 4 == 2) ? 0 : 12;
         if (phase == 4 || phase == 7) begin
            rsp_hold_cycles = HoldCycles;
         end
         repeat (PhaseWrites) send_random_write();
      end

      wait_until_idle();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
